### hw/rtl/lvm_pkg.sv
package lvm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH = 2;

	typedef logic [2:0][31:0] vec32_t;

	typedef struct packed {
		vec32_t eye;
		vec32_t dz;
		vec32_t du;
	} item_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SQ,
		N_SQRT,
		N_LEN,
		N_DIV,
		N_DONE
	} norm_st_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NZ,
		B_NY0,
		B_CX,
		B_NX,
		B_CY,
		B_NY,
		B_ROW
	} back_st_t;

endpackage

### hw/rtl/lvm_queue.sv
module lvm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lvm_pkg::item_t wdata,
	input  logic           pop,
	output lvm_pkg::item_t rdata,
	output logic           full,
	output logic           nonempty
);

	localparam int PW = (lvm_pkg::QDEPTH > 1) ? $clog2(lvm_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(lvm_pkg::QDEPTH + 1);
	localparam logic [PW-1:0] LASTP = PW'(lvm_pkg::QDEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(lvm_pkg::QDEPTH);

	lvm_pkg::item_t mem_q [lvm_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == FULLC);
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == LASTP) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == LASTP) ? '0 : rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

### hw/rtl/lvm_front.sv
module lvm_front (
	input  logic             start,
	input  logic             q_full,
	input  lvm_pkg::vec32_t  eye,
	input  lvm_pkg::vec32_t  aim,
	input  lvm_pkg::vec32_t  upw,
	output logic             busy,
	output logic             push,
	output lvm_pkg::item_t   item
);

	logic signed [32:0] dz [3];
	logic signed [32:0] du [3];

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		item.eye = eye;
		for (int i = 0; i < 3; i++) begin
			dz[i] = $signed({aim[i][31], aim[i]}) - $signed({eye[i][31], eye[i]});
			du[i] = $signed({upw[i][31], upw[i]}) - $signed({eye[i][31], eye[i]});
			if (dz[i][32] != dz[i][31]) item.dz[i] = dz[i][32] ? 32'h80000000 : 32'h7FFFFFFF;
			else item.dz[i] = dz[i][31:0];
			if (du[i][32] != du[i][31]) item.du[i] = du[i][32] ? 32'h80000000 : 32'h7FFFFFFF;
			else item.du[i] = du[i][31:0];
		end
	end

endmodule

### hw/rtl/lvm_norm.sv
module lvm_norm #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
	localparam int AW = FRAC_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lvm_pkg::vec32_t       vin,
	output logic                  done,
	output logic                  degen,
	output logic [2:0][AW-1:0]    vout
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int DW = $clog2(FRAC_BITS + 1);
	localparam logic [DW-1:0] DLAST = DW'(FRAC_BITS);

	lvm_pkg::norm_st_t st_q, st_d;

	logic [2:0][31:0] mag_q;
	logic [2:0]       neg_q;
	logic [63:0]      sq_s1, s_q, rv_q, rr_q, bit_q;
	logic [1:0]       cnt_q, ci_q;
	logic [31:0]      len_q;
	logic [DW-1:0]    di_q;
	logic             ld_q;
	logic [32:0]      rem_q;
	logic [FRAC_BITS:0] nl_q, qt_q;
	logic [2:0][AW-1:0] vout_q;
	logic             degen_q;

	logic [1:0]       sel;
	logic [63:0]      st_t;
	logic [NW-1:0]    num;
	logic [33:0]      dt;
	logic             ge;
	logic [33:0]      rn;
	logic [FRAC_BITS:0] qn;
	logic [AW-1:0]    qa;

	always_comb begin
		sel  = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
		st_t = rr_q + bit_q;
		num  = {mag_q[ci_q], {FRAC_BITS{1'b0}}} + {{FRAC_BITS{1'b0}}, 1'b0, len_q[31:1]};
		dt   = {rem_q, nl_q[FRAC_BITS]};
		ge   = (dt >= {2'b00, len_q});
		rn   = ge ? dt - {2'b00, len_q} : dt;
		qn   = {qt_q[FRAC_BITS-1:0], ge};
		qa   = {1'b0, qn};
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			lvm_pkg::N_IDLE: if (start) st_d = lvm_pkg::N_SQ;
			lvm_pkg::N_SQ:   if (cnt_q == 2'd3) st_d = lvm_pkg::N_SQRT;
			lvm_pkg::N_SQRT: if (bit_q[0]) st_d = lvm_pkg::N_LEN;
			lvm_pkg::N_LEN:  st_d = (len_q == '0) ? lvm_pkg::N_DONE : lvm_pkg::N_DIV;
			lvm_pkg::N_DIV:  if (!ld_q && di_q == DLAST && ci_q == 2'd2) st_d = lvm_pkg::N_DONE;
			lvm_pkg::N_DONE: st_d = lvm_pkg::N_IDLE;
			default: st_d = lvm_pkg::N_IDLE;
		endcase
	end

	always_comb begin
		done  = (st_q == lvm_pkg::N_DONE);
		degen = degen_q;
		vout  = vout_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= lvm_pkg::N_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			lvm_pkg::N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vin[i][31];
						mag_q[i] <= vin[i][31] ? (~vin[i] + 1'b1) : vin[i];
					end
					s_q     <= '0;
					cnt_q   <= '0;
					degen_q <= 1'b0;
				end
			end
			lvm_pkg::N_SQ: begin
				sq_s1 <= mag_q[sel] * mag_q[sel];
				if (cnt_q != 2'd0) s_q <= s_q + sq_s1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					rv_q  <= s_q + sq_s1;
					rr_q  <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			lvm_pkg::N_SQRT: begin
				if (rv_q >= st_t) begin
					rv_q <= rv_q - st_t;
					rr_q <= (rr_q >> 1) + bit_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					len_q <= (rv_q >= st_t) ? 32'((rr_q >> 1) + bit_q) : 32'(rr_q >> 1);
				end
			end
			lvm_pkg::N_LEN: begin
				ci_q <= '0;
				ld_q <= 1'b1;
				if (len_q == '0) begin
					degen_q <= 1'b1;
					vout_q  <= '0;
				end
			end
			lvm_pkg::N_DIV: begin
				if (ld_q) begin
					rem_q <= {2'b00, num[NW-1:FRAC_BITS+1]};
					nl_q  <= num[FRAC_BITS:0];
					qt_q  <= '0;
					di_q  <= '0;
					ld_q  <= 1'b0;
				end else begin
					rem_q <= rn[32:0];
					nl_q  <= nl_q << 1;
					qt_q  <= qn;
					di_q  <= di_q + 1'b1;
					if (di_q == DLAST) begin
						vout_q[ci_q] <= neg_q[ci_q] ? (~qa + 1'b1) : qa;
						ci_q <= ci_q + 1'b1;
						ld_q <= 1'b1;
					end
				end
			end
			lvm_pkg::N_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/lvm_back.sv
module lvm_back #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  lvm_pkg::item_t     q_item,
	output logic               q_pop,
	output logic               done,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               degenerate,
	output logic               last_row
);

	localparam int AW = FRAC_BITS + 2;
	localparam int CW = 2 * AW + 1;
	localparam int PW = AW + 33;
	localparam int SW = PW + 2;
	localparam logic [CW-1:0] CHALF = CW'(1) << (FRAC_BITS - 1);
	localparam logic [SW-1:0] SHALF = SW'(1) << (FRAC_BITS - 1);

	lvm_pkg::back_st_t st_q, st_d;

	lvm_pkg::vec32_t   eye_q, dz_q, du_q, cr_q;
	logic [2:0][AW-1:0] z_q, y0_q, x_q, y_q;
	logic              launched_q, ph_q, dg_q, done_q;
	logic [1:0]        k_q;
	logic signed [2*AW-1:0] p1_s1, p2_s1;
	logic signed [PW-1:0]   prod_s1 [3];
	logic [1:0]        ri_q;
	logic signed [31:0] c0_q, c1_q, c2_q, c3_q;
	logic              last_q;

	logic              nrm_start, nrm_done, nrm_degen;
	lvm_pkg::vec32_t   nrm_vin;
	logic [2:0][AW-1:0] nrm_vout;
	logic              in_norm;

	logic [2:0][AW-1:0] ca, cb, rsel;
	logic signed [AW-1:0] m1a, m1b, m2a, m2b;
	logic [CW-1:0]     cd, cm, crnd;
	logic [CW-1:0]     cres;
	logic signed [32:0] ne [3];
	logic [SW-1:0]     sm, smag, srnd, sv;
	logic [31:0]       sat;

	lvm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nrm_start),
		.vin    (nrm_vin),
		.done   (nrm_done),
		.degen  (nrm_degen),
		.vout   (nrm_vout)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			lvm_pkg::B_IDLE: if (q_valid) st_d = lvm_pkg::B_NZ;
			lvm_pkg::B_NZ:   if (nrm_done) st_d = lvm_pkg::B_NY0;
			lvm_pkg::B_NY0:  if (nrm_done) st_d = lvm_pkg::B_CX;
			lvm_pkg::B_CX:   if (ph_q && k_q == 2'd2) st_d = lvm_pkg::B_NX;
			lvm_pkg::B_NX:   if (nrm_done) st_d = lvm_pkg::B_CY;
			lvm_pkg::B_CY:   if (ph_q && k_q == 2'd2) st_d = lvm_pkg::B_NY;
			lvm_pkg::B_NY:   if (nrm_done) st_d = lvm_pkg::B_ROW;
			lvm_pkg::B_ROW:  if (ph_q && k_q == 2'd2) st_d = lvm_pkg::B_IDLE;
			default: st_d = lvm_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		in_norm = (st_q == lvm_pkg::B_NZ) || (st_q == lvm_pkg::B_NY0) ||
		          (st_q == lvm_pkg::B_NX) || (st_q == lvm_pkg::B_NY);
		q_pop     = (st_q == lvm_pkg::B_IDLE) && q_valid;
		nrm_start = in_norm && !launched_q;
		unique case (st_q)
			lvm_pkg::B_NZ:  nrm_vin = dz_q;
			lvm_pkg::B_NY0: nrm_vin = du_q;
			default:        nrm_vin = cr_q;
		endcase
		done       = done_q;
		row_index  = ri_q;
		col0       = c0_q;
		col1       = c1_q;
		col2       = c2_q;
		col3       = c3_q;
		degenerate = dg_q;
		last_row   = last_q;
	end

	always_comb begin
		if (st_q == lvm_pkg::B_CX) begin
			ca = z_q;
			cb = y0_q;
		end else begin
			ca = x_q;
			cb = z_q;
		end
		unique case (k_q)
			2'd0: begin
				m1a = ca[1]; m1b = cb[2]; m2a = ca[2]; m2b = cb[1];
			end
			2'd1: begin
				m1a = ca[2]; m1b = cb[0]; m2a = ca[0]; m2b = cb[2];
			end
			default: begin
				m1a = ca[0]; m1b = cb[1]; m2a = ca[1]; m2b = cb[0];
			end
		endcase
		cd   = {p1_s1[2*AW-1], p1_s1} - {p2_s1[2*AW-1], p2_s1};
		cm   = cd[CW-1] ? (~cd + 1'b1) : cd;
		crnd = (cm + CHALF) >> FRAC_BITS;
		cres = cd[CW-1] ? (~crnd + 1'b1) : crnd;

		unique case (k_q)
			2'd0: rsel = x_q;
			2'd1: rsel = y_q;
			default: begin
				for (int i = 0; i < 3; i++) rsel[i] = ~z_q[i] + 1'b1;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			ne[i] = -$signed({eye_q[i][31], eye_q[i]});
		end
		sm = {{2{prod_s1[0][PW-1]}}, prod_s1[0]} + {{2{prod_s1[1][PW-1]}}, prod_s1[1]} +
		     {{2{prod_s1[2][PW-1]}}, prod_s1[2]};
		smag = sm[SW-1] ? (~sm + 1'b1) : sm;
		srnd = (smag + SHALF) >> FRAC_BITS;
		sv   = sm[SW-1] ? (~srnd + 1'b1) : srnd;
		if (sv[SW-1:31] != {(SW-31){sv[SW-1]}}) sat = sv[SW-1] ? 32'h80000000 : 32'h7FFFFFFF;
		else sat = sv[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= lvm_pkg::B_IDLE;
			launched_q <= 1'b0;
			k_q        <= '0;
			ph_q       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (nrm_start) launched_q <= 1'b1;
			else if (nrm_done) launched_q <= 1'b0;
			if (st_q == lvm_pkg::B_CX || st_q == lvm_pkg::B_CY || st_q == lvm_pkg::B_ROW) begin
				ph_q <= ~ph_q;
				if (ph_q) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
			end else begin
				ph_q <= 1'b0;
				k_q  <= '0;
			end
			done_q <= (st_q == lvm_pkg::B_ROW) && ph_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			eye_q <= q_item.eye;
			dz_q  <= q_item.dz;
			du_q  <= q_item.du;
			dg_q  <= 1'b0;
		end
		if (in_norm && nrm_done) begin
			dg_q <= dg_q | nrm_degen;
			unique case (st_q)
				lvm_pkg::B_NZ:  z_q  <= nrm_vout;
				lvm_pkg::B_NY0: y0_q <= nrm_vout;
				lvm_pkg::B_NX:  x_q  <= nrm_vout;
				default:        y_q  <= nrm_vout;
			endcase
		end
		if (st_q == lvm_pkg::B_CX || st_q == lvm_pkg::B_CY) begin
			if (!ph_q) begin
				p1_s1 <= m1a * m1b;
				p2_s1 <= m2a * m2b;
			end else begin
				cr_q[k_q] <= cres[31:0];
			end
		end
		if (st_q == lvm_pkg::B_ROW) begin
			if (!ph_q) begin
				for (int i = 0; i < 3; i++) prod_s1[i] <= $signed(rsel[i]) * ne[i];
			end else begin
				ri_q   <= k_q;
				c0_q   <= 32'($signed(rsel[0]));
				c1_q   <= 32'($signed(rsel[1]));
				c2_q   <= 32'($signed(rsel[2]));
				c3_q   <= sat;
				last_q <= (k_q == 2'd2);
			end
		end
	end

endmodule

### hw/rtl/lookat_view_matrix_top.sv
// Each item passes through the bit-serial square root and divider of the shared normalizer, which
// the back end uses for all four vectors in turn; the three rows then follow one after another.
// A two-entry queue takes new items while the back end works on an earlier one.
// Reset: arst_n clears the queue and all sequencers; busy is low after reset.
// The receiver cannot stall: each row is valid only in the cycle that done is high.
module lookat_view_matrix_top #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] aim_x,
	input  logic signed [31:0] aim_y,
	input  logic signed [31:0] aim_z,
	input  logic signed [31:0] upward_x,
	input  logic signed [31:0] upward_y,
	input  logic signed [31:0] upward_z,
	output logic               done,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               degenerate,
	output logic               last_row
);

	lvm_pkg::item_t w_item, r_item;
	logic           push, pop, q_full, q_valid;

	lvm_front u_front (
		.start  (start),
		.q_full (q_full),
		.eye    ({eye_z, eye_y, eye_x}),
		.aim    ({aim_z, aim_y, aim_x}),
		.upw    ({upward_z, upward_y, upward_x}),
		.busy   (busy),
		.push   (push),
		.item   (w_item)
	);

	lvm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (w_item),
		.pop      (pop),
		.rdata    (r_item),
		.full     (q_full),
		.nonempty (q_valid)
	);

	lvm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (r_item),
		.q_pop      (pop),
		.done       (done),
		.row_index  (row_index),
		.col0       (col0),
		.col1       (col1),
		.col2       (col2),
		.col3       (col3),
		.degenerate (degenerate),
		.last_row   (last_row)
	);

endmodule
